/* rtl/mcc_pkg.sv */
// types and constants shared by the multiplier collision checker
`timescale 1ns / 1ps
package mcc_pkg;

   localparam int WORD_W  = 64;
   localparam int GEN_W   = 32;
   localparam int COUNT_W = 13;
   localparam int POS_W   = 12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

   // top byte of the precheck product and the minimum number of ones in it
   localparam int TOP_LSB      = 56;
   localparam int TOP_W        = 8;
   localparam int MIN_TOP_BITS = 6;

   typedef logic [1:0] status_type;
   localparam status_type ST_VALID    = 2'd0;
   localparam status_type ST_REJECTED = 2'd1;
   localparam status_type ST_COLLIDED = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MAGIC = 2'd0;
   localparam csr_index_type CSR_SHIFT = 2'd1;
   localparam csr_index_type CSR_MASK  = 2'd2;

   localparam logic [5:0] SHIFT_RESET = 6'd52;

   typedef struct packed {
      logic [GEN_W-1:0]  tag;
      logic [WORD_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam int RSP_BITS = 2 + POS_W + COUNT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

endpackage

/* rtl/magic_multiplier_collision_check.sv */
// top level: tests one candidate multiplier per trial against a tag/value store
`timescale 1ns / 1ps
// Usage
//   req channel: one word per (occupancy, reference) pair, tlast marks the last
//   pair of a trial. rsp channel: one word per trial with status, position of
//   the first colliding pair and the number of pairs seen. csr channel: writes
//   magic (0), shift (1) and the occupancy mask (2); taken only while no pair
//   is in flight, and a pending csr write holds off req_tready.
// Sequence
//   Pairs are taken one at a time. An accepted pair runs the low, high-low and
//   low-high partial products on the shared 32x32 multiplier for the low 64
//   bits of occupancy*magic, then forms the index and reads the store, compares
//   and writes back, and retires. The first pair of a trial first runs
//   mask*magic and the top-byte check. Pairs of a rejected or collided trial go
//   from accept to retire. The result is loaded into rsp as its last pair retires.
// Reset
//   After reset the tag store is cleared, one entry a cycle, through all
//   2^INDEX_BITS entries; req_tready stays low meanwhile, csr writes are taken.
// Stall
//   The rsp word sits in an output register; pairs keep flowing while it waits,
//   and only a trial end that finds the register still full holds req_tready.
module magic_multiplier_collision_check #(
   parameter int INDEX_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [2*mcc_pkg::WORD_W-1:0] req_tdata,  // occupancy[63:0], reference[127:64]
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status[1:0], conflict_position[13:2], items_seen[26:14], zeros above
   output logic [mcc_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  mcc_pkg::csr_index_type       csr_index,
   input  logic [mcc_pkg::WORD_W-1:0]   csr_wdata
);

   localparam int DEPTH = 2 ** INDEX_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_HL = 2'd1;
   localparam logic [1:0] STEP_LH = 2'd2;

   localparam int HALF = mcc_pkg::WORD_W / 2;

   // configuration registers
   logic [mcc_pkg::WORD_W-1:0] magic_ff, magic_in;
   logic [5:0]                 shift_ff, shift_in;
   logic [mcc_pkg::WORD_W-1:0] mask_ff, mask_in;

   // control
   logic [2:0]                  state_ff, state_in;
   logic [1:0]                  step_ff, step_in;
   logic                        pre_ff, pre_in;
   logic [INDEX_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic [mcc_pkg::GEN_W-1:0]   gen_ff, gen_in;
   logic                        open_ff, open_in;
   mcc_pkg::status_type         status_ff, status_in;
   logic [mcc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [mcc_pkg::POS_W-1:0]   conflict_ff, conflict_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [mcc_pkg::WORD_W-1:0]  op_a_ff, op_a_in;
   logic [mcc_pkg::WORD_W-1:0]  acc_ff, acc_in;
   logic [mcc_pkg::WORD_W-1:0]  occ_ff, occ_in;
   logic [mcc_pkg::WORD_W-1:0]  ref_ff, ref_in;
   logic                        last_ff, last_in;
   logic [mcc_pkg::COUNT_W-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0]       idx_ff, idx_in;
   logic [mcc_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // multiplier and store
   logic [HALF-1:0]             mul_x, mul_y;
   logic [mcc_pkg::WORD_W-1:0]  mul_p;
   logic [mcc_pkg::WORD_W-1:0]  shifted;
   logic [3:0]                  top_ones;
   logic                        ram_we;
   logic [INDEX_BITS-1:0]       ram_waddr, ram_raddr;
   mcc_pkg::entry_type          ram_wentry, ram_rentry;
   logic [mcc_pkg::ENTRY_W-1:0] ram_rdata;
   logic                        req_take;
   logic                        rsp_free;

   mcc_ram #(
      .WIDTH (mcc_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_rentry = mcc_pkg::entry_type'(ram_rdata);

   // low 64 bits of op_a*magic from three 32x32 partial products
   always_comb begin
      case (step_ff)
         STEP_HL: begin
            mul_x = op_a_ff[mcc_pkg::WORD_W-1:HALF];
            mul_y = magic_ff[HALF-1:0];
         end
         STEP_LH: begin
            mul_x = op_a_ff[HALF-1:0];
            mul_y = magic_ff[mcc_pkg::WORD_W-1:HALF];
         end
         default: begin
            mul_x = op_a_ff[HALF-1:0];
            mul_y = magic_ff[HALF-1:0];
         end
      endcase
      mul_p = mcc_pkg::WORD_W'(mul_x) * mcc_pkg::WORD_W'(mul_y);
   end

   always_comb begin
      top_ones = '0;
      for (int i = 0; i < mcc_pkg::TOP_W; i++) begin
         top_ones = top_ones + 4'(acc_ff[mcc_pkg::TOP_LSB + i]);
      end
      shifted = acc_ff >> shift_ff;
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // a pending csr write goes first, so it never lands inside a pair
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE) || (state_ff == S_CLEAR);

   always_comb begin
      magic_in     = magic_ff;
      shift_in     = shift_ff;
      mask_in      = mask_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      pre_in       = pre_ff;
      clr_addr_in  = clr_addr_ff;
      gen_in       = gen_ff;
      open_in      = open_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      conflict_in  = conflict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_a_in      = op_a_ff;
      acc_in       = acc_ff;
      occ_in       = occ_ff;
      ref_in       = ref_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wentry   = '{tag: gen_ff, value: ref_ff};
      ram_raddr    = shifted[INDEX_BITS-1:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            mcc_pkg::CSR_MAGIC: magic_in = csr_wdata;
            mcc_pkg::CSR_SHIFT: shift_in = csr_wdata[5:0];
            mcc_pkg::CSR_MASK:  mask_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wentry  = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == INDEX_BITS'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               occ_in  = req_tdata[mcc_pkg::WORD_W-1:0];
               ref_in  = req_tdata[2*mcc_pkg::WORD_W-1:mcc_pkg::WORD_W];
               last_in = req_tlast;
               step_in = STEP_LL;
               if (!open_ff) begin
                  // first word of a trial: new generation, then the precheck
                  open_in     = 1'b1;
                  gen_in      = gen_ff + 1'b1;
                  status_in   = mcc_pkg::ST_VALID;
                  conflict_in = '0;
                  pos_in      = '0;
                  count_in    = mcc_pkg::COUNT_W'(1);
                  op_a_in     = mask_ff;
                  pre_in      = 1'b1;
                  state_in    = S_MUL;
               end else begin
                  pos_in = count_ff;
                  if (count_ff != mcc_pkg::COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  op_a_in  = req_tdata[mcc_pkg::WORD_W-1:0];
                  pre_in   = 1'b0;
                  state_in = (status_ff == mcc_pkg::ST_VALID) ? S_MUL : S_DONE;
               end
            end
         end
         S_MUL: begin
            case (step_ff)
               STEP_LL: begin
                  acc_in  = mul_p;
                  step_in = STEP_HL;
               end
               STEP_HL: begin
                  acc_in[mcc_pkg::WORD_W-1:HALF] = acc_ff[mcc_pkg::WORD_W-1:HALF]
                                                 + mul_p[HALF-1:0];
                  step_in = STEP_LH;
               end
               default: begin
                  acc_in[mcc_pkg::WORD_W-1:HALF] = acc_ff[mcc_pkg::WORD_W-1:HALF]
                                                 + mul_p[HALF-1:0];
                  state_in = S_EVAL;
               end
            endcase
         end
         S_EVAL: begin
            if (pre_ff) begin
               if (top_ones < 4'(mcc_pkg::MIN_TOP_BITS)) begin
                  status_in = mcc_pkg::ST_REJECTED;
                  state_in  = S_DONE;
               end else begin
                  op_a_in  = occ_ff;
                  pre_in   = 1'b0;
                  step_in  = STEP_LL;
                  state_in = S_MUL;
               end
            end else begin
               // store read issued here, data back in the compare cycle
               idx_in   = shifted[INDEX_BITS-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (ram_rentry.tag != gen_ff) begin
               ram_we = 1'b1;
            end else if (ram_rentry.value != ref_ff) begin
               status_in   = mcc_pkg::ST_COLLIDED;
               conflict_in = (pos_ff > mcc_pkg::COUNT_W'(mcc_pkg::POS_MAX))
                           ? mcc_pkg::POS_MAX : pos_ff[mcc_pkg::POS_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mcc_pkg::RSP_W'({count_ff,
                  (status_ff == mcc_pkg::ST_COLLIDED) ? conflict_ff
                                                      : {mcc_pkg::POS_W{1'b0}},
                  status_ff});
               open_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= '0;
         shift_ff     <= mcc_pkg::SHIFT_RESET;
         mask_ff      <= '0;
         state_ff     <= S_CLEAR;
         step_ff      <= STEP_LL;
         pre_ff       <= 1'b0;
         clr_addr_ff  <= '0;
         gen_ff       <= '0;
         open_ff      <= 1'b0;
         status_ff    <= mcc_pkg::ST_VALID;
         count_ff     <= '0;
         conflict_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         magic_ff     <= magic_in;
         shift_ff     <= shift_in;
         mask_ff      <= mask_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         pre_ff       <= pre_in;
         clr_addr_ff  <= clr_addr_in;
         gen_ff       <= gen_in;
         open_ff      <= open_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         conflict_ff  <= conflict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff     <= op_a_in;
      acc_ff      <= acc_in;
      occ_ff      <= occ_in;
      ref_ff      <= ref_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a non-collision result never reports a conflict position
   a_no_pos_without_collision: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != mcc_pkg::ST_COLLIDED |-> rsp_tdata[13:2] == '0)
      else $error("conflict position set on a non-collision result");

   // the store is only written back while the trial is still valid
   a_write_only_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we && state_ff == S_CMP |-> status_ff == mcc_pkg::ST_VALID)
      else $error("store written during a failed trial");

   // generation moves only by one, and only when a trial opens
   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      gen_ff != $past(gen_ff) |-> gen_ff == $past(gen_ff) + 1'b1 && $rose(open_ff))
      else $error("generation changed outside a trial start");

   // a result is loaded only when the last word of a trial retires
   a_rsp_on_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE && $past(last_ff))
      else $error("result produced without a last word");

endmodule

/* rtl/mcc_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps
module mcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/magic_multiplier_collision_check_tb.sv */
// testbench for the candidate-multiplier collision checker
`timescale 1ns / 1ps
module magic_multiplier_collision_check_tb;

   localparam int INDEX_BITS  = 12;
   localparam int STORE_DEPTH = 1 << INDEX_BITS;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE      = 16;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASE_PAIRS = 150;
   localparam mcc_pkg::csr_index_type CSR_UNUSED = 2'd3;

   typedef struct packed {
      mcc_pkg::status_type         status;
      logic [mcc_pkg::POS_W-1:0]   position;
      logic [mcc_pkg::COUNT_W-1:0] items;
   } verdict_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [2*mcc_pkg::WORD_W-1:0]   req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mcc_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   mcc_pkg::csr_index_type         csr_index = mcc_pkg::CSR_MAGIC;
   logic [mcc_pkg::WORD_W-1:0]     csr_wdata = '0;

   // shadow of the block's registers and store
   logic [mcc_pkg::WORD_W-1:0]     magic_shadow;
   logic [5:0]                     shift_shadow;
   logic [mcc_pkg::WORD_W-1:0]     mask_shadow;
   logic [mcc_pkg::GEN_W-1:0]      tag_mirror [STORE_DEPTH];
   logic [mcc_pkg::WORD_W-1:0]     value_mirror [STORE_DEPTH];
   logic [mcc_pkg::GEN_W-1:0]      gen_mirror;
   logic                           open_mirror;
   mcc_pkg::status_type            status_mirror;
   logic [mcc_pkg::COUNT_W-1:0]    count_mirror;
   logic [mcc_pkg::POS_W-1:0]      conflict_mirror;

   verdict_type                    pending_verdicts [$];

   int                             errors = 0;
   int                             cycle_count = 0;
   int                             req_idle_pct = 0;
   int                             rsp_stall_pct = 0;
   int                             hold_left = 0;
   int                             pairs_sent = 0;
   int                             csr_writes = 0;
   int                             n_valid = 0;
   int                             n_rejected = 0;
   int                             n_collided = 0;
   bit                             req_offered = 1'b0;
   realtime                        req_dropped_at = -1.0;

   magic_multiplier_collision_check #(.INDEX_BITS(INDEX_BITS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               pending_verdicts.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [mcc_pkg::WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // hash one pair against the mirrored store, queue a verdict on the last word
   task automatic score_pair(input logic [mcc_pkg::WORD_W-1:0] occ,
                             input logic [mcc_pkg::WORD_W-1:0] refv, input logic last);
      logic [mcc_pkg::WORD_W-1:0]  product;
      logic [INDEX_BITS-1:0]       slot;
      logic [mcc_pkg::COUNT_W-1:0] pos;
      verdict_type                 v;
      if (!open_mirror) begin
         open_mirror     = 1'b1;
         gen_mirror      = gen_mirror + 1'b1;
         count_mirror    = '0;
         conflict_mirror = '0;
         product         = mask_shadow * magic_shadow;
         status_mirror   = ($countones(product[mcc_pkg::TOP_LSB +: mcc_pkg::TOP_W]) <
                            mcc_pkg::MIN_TOP_BITS) ? mcc_pkg::ST_REJECTED : mcc_pkg::ST_VALID;
      end
      pos = count_mirror;
      if (count_mirror != mcc_pkg::COUNT_MAX) count_mirror = count_mirror + 1'b1;
      if (status_mirror == mcc_pkg::ST_VALID) begin
         product = occ * magic_shadow;
         slot    = INDEX_BITS'(product >> shift_shadow);
         if (tag_mirror[slot] != gen_mirror) begin
            tag_mirror[slot]   = gen_mirror;
            value_mirror[slot] = refv;
         end else if (value_mirror[slot] != refv) begin
            status_mirror   = mcc_pkg::ST_COLLIDED;
            conflict_mirror = (pos > mcc_pkg::COUNT_W'(mcc_pkg::POS_MAX)) ?
                              mcc_pkg::POS_MAX : pos[mcc_pkg::POS_W-1:0];
         end
      end
      if (last) begin
         v.status   = status_mirror;
         v.position = (status_mirror == mcc_pkg::ST_COLLIDED) ? conflict_mirror : '0;
         v.items    = count_mirror;
         pending_verdicts.insert(pending_verdicts.size(), v);
         open_mirror = 1'b0;
      end
   endtask

   task automatic send_pair(input logic [mcc_pkg::WORD_W-1:0] occ,
                            input logic [mcc_pkg::WORD_W-1:0] refv, input logic last);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         if (req_offered) begin
            req_tvalid    <= 1'b0;
            req_offered    = 1'b0;
            req_dropped_at = $realtime;
         end
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      // valid was just dropped in this step, let it take effect first
      if (!req_offered && $realtime == req_dropped_at) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {refv, occ};
      req_tlast  <= last;
      req_offered = 1'b1;
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
      score_pair(occ, refv, last);
   endtask

   task automatic drain_results();
      if (req_offered) begin
         req_tvalid    <= 1'b0;
         req_offered    = 1'b0;
         req_dropped_at = $realtime;
      end
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr_word(input mcc_pkg::csr_index_type idx,
                                 input logic [mcc_pkg::WORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         mcc_pkg::CSR_MAGIC: magic_shadow = val;
         mcc_pkg::CSR_SHIFT: shift_shadow = val[5:0];
         mcc_pkg::CSR_MASK:  mask_shadow  = val;
         default: ;
      endcase
   endtask

   // only between trials, once the block has gone quiet
   task automatic set_config(input logic [mcc_pkg::WORD_W-1:0] magic, input logic [5:0] shift,
                             input logic [mcc_pkg::WORD_W-1:0] mask, input bit poke_unused);
      logic [mcc_pkg::WORD_W-1:0] junk;
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (poke_unused) write_csr_word(CSR_UNUSED, rand64());
      write_csr_word(mcc_pkg::CSR_MAGIC, magic);
      junk = rand64();
      write_csr_word(mcc_pkg::CSR_SHIFT, {junk[mcc_pkg::WORD_W-1:6], shift});
      write_csr_word(mcc_pkg::CSR_MASK, mask);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_monitor
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tdata[1:0];
         got.position = rsp_tdata[2 +: mcc_pkg::POS_W];
         got.items    = rsp_tdata[2 + mcc_pkg::POS_W +: mcc_pkg::COUNT_W];
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected verdict word %h", $time, rsp_tdata);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.status != want.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            end
            if (got.position != want.position) begin
               errors++;
               $display("%0t: conflict_position expected %0d got %0d", $time,
                        want.position, got.position);
            end
            if (got.items != want.items) begin
               errors++;
               $display("%0t: items_seen expected %0d got %0d", $time, want.items, got.items);
            end
            case (want.status)
               mcc_pkg::ST_VALID:    n_valid++;
               mcc_pkg::ST_REJECTED: n_rejected++;
               default:              n_collided++;
            endcase
         end
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // registers at reset values: zero product, so the precheck rejects
   task automatic test_reset_config();
      send_pair(rand64(), rand64(), 1'b0);
      send_pair(rand64(), rand64(), 1'b1);
      drain_results();
   endtask

   task automatic test_directed();
      set_config(64'hFF00_0000_0000_0001, 6'd52, 64'h1, 1'b1);
      // destructive collision, then an ignored pair
      send_pair(64'h0, 64'h0, 1'b0);
      send_pair('1, '1, 1'b0);
      send_pair(64'h0, '1, 1'b0);
      send_pair(64'h5, 64'h7, 1'b1);
      send_pair('1, 64'h0, 1'b1);
      // same index, same reference is harmless
      send_pair(64'h3, 64'h9, 1'b0);
      send_pair(64'h3, 64'h9, 1'b1);
      // shift of zero, index wraps to the low bits; exactly six top ones
      set_config(64'hFC00_0000_0000_0001, 6'd0, 64'h1, 1'b0);
      send_pair(64'h1, 64'h1, 1'b0);
      send_pair(64'h1001, 64'h2, 1'b1);
      // five top ones only
      set_config(64'hF800_0000_0000_0001, 6'd63, 64'h1, 1'b0);
      send_pair(64'h0, 64'h0, 1'b0);
      send_pair(64'h0, 64'h1, 1'b1);
      set_config('1, 6'd63, '1, 1'b0);
      send_pair('1, '1, 1'b1);
      // one index bit
      set_config(64'hFF00_0000_0000_0001, 6'd63, 64'h1, 1'b0);
      send_pair(64'h0, 64'hA, 1'b0);
      send_pair(64'h1, 64'hB, 1'b0);
      send_pair(64'h8000_0000_0000_0000, 64'hC, 1'b1);
      drain_results();
   endtask

   task automatic test_random_trials();
      int                         phase;
      int                         sent;
      int                         len;
      int                         trials_left;
      int                         tries;
      int                         i;
      bit                         want_dense;
      logic [mcc_pkg::WORD_W-1:0] magic;
      logic [mcc_pkg::WORD_W-1:0] mask;
      logic [mcc_pkg::WORD_W-1:0] product;
      logic [5:0]                 shift;
      logic [mcc_pkg::WORD_W-1:0] occ_space;
      logic [mcc_pkg::WORD_W-1:0] ref_keep;
      logic [mcc_pkg::WORD_W-1:0] occ;
      logic [mcc_pkg::WORD_W-1:0] prev_occ;
      logic [mcc_pkg::WORD_W-1:0] refv;
      int                         pick;
      trials_left = 0;
      occ_space   = '1;
      ref_keep    = '1;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin req_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         sent = 0;
         while (sent < PHASE_PAIRS) begin
            if (trials_left == 0) begin
               want_dense = ($urandom_range(0, 99) < 80);
               tries = 0;
               do begin
                  magic   = rand64();
                  mask    = rand64();
                  product = mask * magic;
                  tries++;
               end while (want_dense && tries < 500 &&
                          $countones(product[mcc_pkg::TOP_LSB +: mcc_pkg::TOP_W]) <
                          mcc_pkg::MIN_TOP_BITS);
               shift = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(52, 63))
                                                    : 6'($urandom_range(0, 51));
               set_config(magic, shift, mask, $urandom_range(0, 9) == 0);
               occ_space = ($urandom_range(0, 1) != 0) ? (rand64() & rand64()) : rand64();
               pick = $urandom_range(0, 2);
               ref_keep = (pick == 0) ? '1 : (pick == 1) ? rand64() : 64'h7;
               trials_left = $urandom_range(1, 4);
            end
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            prev_occ = rand64() & occ_space;
            for (i = 0; i < len; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 10) begin
                  // noise
                  occ  = rand64();
                  refv = rand64();
               end else if (pick < 20) begin
                  // same key again with another reference
                  occ  = prev_occ;
                  refv = ((occ * 64'h9E37_79B9_7F4A_7C15) & ref_keep) ^ 64'h1;
               end else begin
                  occ  = rand64() & occ_space;
                  refv = (occ * 64'h9E37_79B9_7F4A_7C15) & ref_keep;
               end
               prev_occ = occ;
               send_pair(occ, refv, i == len - 1);
            end
            sent += len;
            trials_left--;
         end
      end
      drain_results();
   endtask

   // receiver holds off while short trials keep coming, so the input stalls
   task automatic test_output_backpressure();
      int i;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_config(64'hFF00_0000_0000_0001, 6'd52, 64'h1, 1'b0);
      hold_left = 400;
      for (i = 0; i < 30; i++) send_pair(rand64(), rand64(), 1'b1);
      drain_results();
   endtask

   initial begin : run
      int k;
      magic_shadow    = '0;
      shift_shadow    = mcc_pkg::SHIFT_RESET;
      mask_shadow     = '0;
      gen_mirror      = '0;
      open_mirror     = 1'b0;
      status_mirror   = mcc_pkg::ST_VALID;
      count_mirror    = '0;
      conflict_mirror = '0;
      for (k = 0; k < STORE_DEPTH; k++) begin
         tag_mirror[k]   = '0;
         value_mirror[k] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_directed();
      test_random_trials();
      test_output_backpressure();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         errors++;
         $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      end
      $display("run covered %0d pairs and %0d register writes in %0d cycles", pairs_sent,
               csr_writes, cycle_count);
      $display("trials checked: %0d valid, %0d rejected, %0d collided, %0d errors", n_valid,
               n_rejected, n_collided, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
